### sv/mspid_pkg.sv
// Shared widths, configuration register indexes and stage word types
// for the incremental PID speed controller. No dependencies.
package mspid_pkg;

    localparam int SPEED_W = 16;          // input speed fields
    localparam int GAIN_W  = 16;          // Q8.8 gains
    localparam int LIMIT_W = 16;          // duty limit and duty output
    localparam int FRAC_W  = 8;           // fraction bits of gains and accumulator
    localparam int ERR_W   = SPEED_W + 2; // error, +/-65535
    localparam int D1_W    = ERR_W + 1;   // first difference of error
    localparam int D2_W    = ERR_W + 2;   // second difference of error
    localparam int PP_W    = GAIN_W + D1_W;
    localparam int PI_W    = GAIN_W + ERR_W;
    localparam int PD_W    = GAIN_W + D2_W;
    localparam int ACC_W   = LIMIT_W + FRAC_W + 2;
    localparam int SUM_W   = PD_W + 2;
    localparam int CFG_IDX_W = 4;

    localparam logic [LIMIT_W-1:0] DUTY_LIMIT_RESET = LIMIT_W'(10000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP_GAIN    = CFG_IDX_W'(0),
        CFG_KI_GAIN    = CFG_IDX_W'(1),
        CFG_KD_GAIN    = CFG_IDX_W'(2),
        CFG_DUTY_LIMIT = CFG_IDX_W'(3)
    } cfg_index_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0]  kp_gain;
        logic signed [GAIN_W-1:0]  ki_gain;
        logic signed [GAIN_W-1:0]  kd_gain;
        logic        [LIMIT_W-1:0] duty_limit;
    } cfg_regs_t;

    typedef struct packed {
        logic signed [ERR_W-1:0] err;
        logic signed [D1_W-1:0]  diff1;
        logic signed [D2_W-1:0]  diff2;
    } err_word_t;

    typedef struct packed {
        logic signed [PP_W-1:0] p_term;
        logic signed [PI_W-1:0] i_term;
        logic signed [PD_W-1:0] d_term;
    } prod_word_t;

endpackage

### sv/mspid_err.sv
// Error stage: forms the tick error and its first and second differences,
// and keeps the error history. Depends on mspid_pkg.
module mspid_err (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [mspid_pkg::SPEED_W-1:0] s_target_speed,
    input  logic signed [mspid_pkg::SPEED_W-1:0] s_measured_speed,
    output logic                                 err_valid,
    input  logic                                 err_ready,
    output mspid_pkg::err_word_t                 err_word
);
    import mspid_pkg::*;

    logic                    valid_reg;
    logic signed [ERR_W-1:0] e1_reg;
    logic signed [ERR_W-1:0] e2_reg;
    err_word_t               word_reg;
    err_word_t               word_next;
    logic                    accept;

    assign s_ready   = !valid_reg || err_ready;
    assign accept    = s_valid && s_ready;
    assign err_valid = valid_reg;
    assign err_word  = word_reg;

    always_comb begin
        word_next.err   = ERR_W'(s_target_speed) - ERR_W'(s_measured_speed);
        word_next.diff1 = D1_W'(word_next.err) - D1_W'(e1_reg);
        word_next.diff2 = D2_W'(word_next.err) - (D2_W'(e1_reg) <<< 1) + D2_W'(e2_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            e1_reg    <= '0;
            e2_reg    <= '0;
        end else begin
            if (s_ready) begin
                valid_reg <= s_valid;
            end
            if (accept) begin
                e1_reg <= word_next.err;
                e2_reg <= e1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            word_reg <= word_next;
        end
    end

endmodule

### sv/mspid_mul.sv
// Product stage: the three gain multiplies, one registered product each.
// Depends on mspid_pkg.
module mspid_mul (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  mspid_pkg::cfg_regs_t  cfg,
    input  logic                  err_valid,
    output logic                  err_ready,
    input  mspid_pkg::err_word_t  err_word,
    output logic                  prod_valid,
    input  logic                  prod_ready,
    output mspid_pkg::prod_word_t prod_word
);
    import mspid_pkg::*;

    logic       valid_reg;
    prod_word_t word_reg;
    prod_word_t word_next;

    assign err_ready  = !valid_reg || prod_ready;
    assign prod_valid = valid_reg;
    assign prod_word  = word_reg;

    always_comb begin
        word_next.p_term = PP_W'(cfg.kp_gain) * PP_W'(err_word.diff1);
        word_next.i_term = PI_W'(cfg.ki_gain) * PI_W'(err_word.err);
        word_next.d_term = PD_W'(cfg.kd_gain) * PD_W'(err_word.diff2);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (err_ready) begin
            valid_reg <= err_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (err_valid && err_ready) begin
            word_reg <= word_next;
        end
    end

endmodule

### sv/mspid_acc.sv
// Accumulate stage: adds the increment to the drive accumulator, clamps it
// to the duty limit and registers direction and duty. Depends on mspid_pkg.
module mspid_acc (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  mspid_pkg::cfg_regs_t                cfg,
    input  logic                                prod_valid,
    output logic                                prod_ready,
    input  mspid_pkg::prod_word_t               prod_word,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_direction,
    output logic [mspid_pkg::LIMIT_W-1:0]       m_duty
);
    import mspid_pkg::*;

    logic                    valid_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] lim;
    logic [ACC_W-1:0]        mag;
    logic [LIMIT_W-1:0]      duty_next;
    logic                    dir_next;
    logic                    direction_reg;
    logic [LIMIT_W-1:0]      duty_reg;

    assign prod_ready  = !valid_reg || m_ready;
    assign m_valid     = valid_reg;
    assign m_direction = direction_reg;
    assign m_duty      = duty_reg;

    always_comb begin
        sum = SUM_W'(acc_reg) + SUM_W'(prod_word.p_term)
            + SUM_W'(prod_word.i_term) + SUM_W'(prod_word.d_term);
        lim = SUM_W'({cfg.duty_limit, FRAC_W'(0)});
        if (sum > lim) begin
            acc_next = ACC_W'(lim);
        end else if (sum < -lim) begin
            acc_next = ACC_W'(-lim);
        end else begin
            acc_next = ACC_W'(sum);
        end
        // truncate toward zero: shift the magnitude
        mag       = acc_next[ACC_W-1] ? ACC_W'(-acc_next) : ACC_W'(acc_next);
        duty_next = mag[FRAC_W +: LIMIT_W];
        dir_next  = !(acc_next[ACC_W-1] && (duty_next != '0));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            acc_reg   <= '0;
        end else begin
            if (prod_ready) begin
                valid_reg <= prod_valid;
            end
            if (prod_valid && prod_ready) begin
                acc_reg <= acc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (prod_valid && prod_ready) begin
            direction_reg <= dir_next;
            duty_reg      <= duty_next;
        end
    end

endmodule

### sv/motor_speed_incremental_pid.sv
// Incremental PID motor speed controller, top level: configuration
// registers and the three-stage pipeline. Depends on mspid_pkg,
// mspid_err, mspid_mul and mspid_acc.
//
// Use: each word on the s_ channel is one control tick (target and
// measured speed). Each tick gives one m_ word: a direction bit and a
// duty magnitude for the PWM. Gains and duty limit are written on the
// cfg_ channel (index 0 kp, 1 ki, 2 kd, 3 duty limit; others ignored),
// which is always ready; write only while no tick is in flight.
// The error stage registers a word when it accepts it; the multiply and
// accumulate stages each register it in turn before m_ shows it.
// Throughput: one word per cycle while m_ready is high, set by the
// accumulator add-and-clamp loop in the last stage.
// Each stage holds one word and takes a new one whenever it is empty or
// its word moves on, so a stalled m_ready fills the pipe (three words)
// before s_ready drops. Results are never dropped or repeated.
// Reset: gains to 0, duty limit to 10000, error history and accumulator
// to zero, pipeline empty.
module motor_speed_incremental_pid (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [mspid_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mspid_pkg::GAIN_W-1:0]           cfg_data,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [mspid_pkg::SPEED_W-1:0]   s_target_speed,
    input  logic signed [mspid_pkg::SPEED_W-1:0]   s_measured_speed,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic                                   m_direction,
    output logic [mspid_pkg::LIMIT_W-1:0]          m_duty
);
    import mspid_pkg::*;

    cfg_regs_t  cfg_reg;
    err_word_t  err_word;
    prod_word_t prod_word;
    logic       err_valid;
    logic       err_ready;
    logic       prod_valid;
    logic       prod_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kp_gain    <= '0;
            cfg_reg.ki_gain    <= '0;
            cfg_reg.kd_gain    <= '0;
            cfg_reg.duty_limit <= DUTY_LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_KP_GAIN:    cfg_reg.kp_gain    <= cfg_data;
                CFG_KI_GAIN:    cfg_reg.ki_gain    <= cfg_data;
                CFG_KD_GAIN:    cfg_reg.kd_gain    <= cfg_data;
                CFG_DUTY_LIMIT: cfg_reg.duty_limit <= cfg_data;
                default: ;
            endcase
        end
    end

    mspid_err u_err (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_target_speed   (s_target_speed),
        .s_measured_speed (s_measured_speed),
        .err_valid        (err_valid),
        .err_ready        (err_ready),
        .err_word         (err_word)
    );

    mspid_mul u_mul (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .err_valid  (err_valid),
        .err_ready  (err_ready),
        .err_word   (err_word),
        .prod_valid (prod_valid),
        .prod_ready (prod_ready),
        .prod_word  (prod_word)
    );

    mspid_acc u_acc (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .prod_valid  (prod_valid),
        .prod_ready  (prod_ready),
        .prod_word   (prod_word),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_direction (m_direction),
        .m_duty      (m_duty)
    );

    // clamped duty never exceeds the limit
    a_duty_in_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_duty <= cfg_reg.duty_limit)
        else $error("duty above limit");

    // reverse drive always carries a nonzero duty
    a_reverse_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_direction) |-> m_duty != '0)
        else $error("reverse direction with zero duty");

    // input stalls only when the whole pipe is full and the output is held
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready && err_valid && prod_valid))
        else $error("input stalled with room in pipeline");

endmodule
